// ===== hdl/tcnf_pkg.sv =====
`default_nettype none

package tcnf_pkg;

    // Command opcodes
    localparam logic [3:0] OP_CHAR    = 4'd0;
    localparam logic [3:0] OP_HEX8    = 4'd1;
    localparam logic [3:0] OP_HEX16   = 4'd2;
    localparam logic [3:0] OP_HEX32   = 4'd3;
    localparam logic [3:0] OP_HEX64   = 4'd4;
    localparam logic [3:0] OP_BIN8    = 4'd5;
    localparam logic [3:0] OP_BIN16   = 4'd6;
    localparam logic [3:0] OP_DEC5    = 4'd7;
    localparam logic [3:0] OP_DECN    = 4'd8;
    localparam logic [3:0] OP_DECAUTO = 4'd9;
    localparam logic [3:0] OP_NEWLINE = 4'd10;

    localparam int MAX_DECIMAL_DIGITS = 10;
    localparam int MAX_CHARS          = 16;
    localparam int DEC_LIMIT = (MAX_DECIMAL_DIGITS < MAX_CHARS) ? MAX_DECIMAL_DIGITS : MAX_CHARS;
    localparam int DEC5_DIGITS        = 5;

    // Binary to BCD conversion: 32 bits in, 10 decimal digits out
    localparam int CONV_BITS   = 32;
    localparam int CONV_CNT_W  = $clog2(CONV_BITS);
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int DEC_PAD_W   = 4 * MAX_CHARS - BCD_W;

    localparam int IDX_W = $clog2(MAX_CHARS);
    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    localparam logic [7:0] ASCII_ZERO       = 8'h30;
    localparam logic [7:0] ASCII_HEX_BASE   = 8'h37;  // 'A' - 0xA
    localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;
    localparam logic [3:0] HEX_TEN          = 4'hA;
    localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;
    localparam logic [7:0] ROW_MAX          = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_NEWLINE,
        CLS_DIRECT,
        CLS_DECIMAL
    } cls_t;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_HEX,
        KIND_BIN,
        KIND_DEC
    } kind_t;

    typedef struct packed {
        logic load;
        logic newline;
        logic conv_step;
        logic set_auto;
        logic emit;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic conv_done;
        logic out_free;
        logic idx_zero;
    } sts_t;

    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        logic [7:0] g;
        if (nib < HEX_TEN)
            g = ASCII_ZERO + {4'b0, nib};
        else
            g = ASCII_HEX_BASE + {4'b0, nib};
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tcnf_ctrl.sv =====
`default_nettype none

module tcnf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire tcnf_pkg::sts_t sts,
    output tcnf_pkg::cmd_t      cmd
);

    tcnf_pkg::state_t state_reg;
    tcnf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tcnf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcnf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (sts.cls)
                        tcnf_pkg::CLS_DIRECT:  state_next = tcnf_pkg::ST_EMIT;
                        tcnf_pkg::CLS_DECIMAL: state_next = tcnf_pkg::ST_CONV;
                        tcnf_pkg::CLS_NONE,
                        tcnf_pkg::CLS_NEWLINE: state_next = tcnf_pkg::ST_IDLE;
                        default:               state_next = tcnf_pkg::ST_IDLE;
                    endcase
                end
            end
            tcnf_pkg::ST_CONV:
            begin
                if (sts.conv_done)
                    state_next = tcnf_pkg::ST_PREP;
            end
            tcnf_pkg::ST_PREP:
            begin
                state_next = tcnf_pkg::ST_EMIT;
            end
            tcnf_pkg::ST_EMIT:
            begin
                if (sts.out_free && sts.idx_zero)
                    state_next = tcnf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcnf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        in_stall      = (state_reg != tcnf_pkg::ST_IDLE);
        cmd.load      = (state_reg == tcnf_pkg::ST_IDLE) && in_valid;
        cmd.newline   = cmd.load && (sts.cls == tcnf_pkg::CLS_NEWLINE);
        cmd.conv_step = (state_reg == tcnf_pkg::ST_CONV);
        cmd.set_auto  = (state_reg == tcnf_pkg::ST_PREP);
        cmd.emit      = (state_reg == tcnf_pkg::ST_EMIT) && sts.out_free;
    end

    a_conv_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcnf_pkg::ST_CONV |=>
            (state_reg == tcnf_pkg::ST_CONV || state_reg == tcnf_pkg::ST_PREP))
        else $error("conversion left to an unexpected state");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcnf_pkg::ST_EMIT && sts.out_free && sts.idx_zero) |=>
            state_reg == tcnf_pkg::ST_IDLE)
        else $error("controller did not return to idle after final character");

endmodule

`default_nettype wire

// ===== hdl/tcnf_dp.sv =====
`default_nettype none

module tcnf_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [7:0]            cfg_data,
    input  wire logic [3:0]            opcode,
    input  wire logic [63:0]           value,
    input  wire logic [3:0]            digit_count,
    output logic [7:0]                 glyph,
    output logic [7:0]                 column,
    output logic [7:0]                 row,
    output logic                       last,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire tcnf_pkg::cmd_t        cmd,
    output tcnf_pkg::sts_t             sts
);

    // Command decode of the waiting input item
    tcnf_pkg::cls_t                   in_cls;
    tcnf_pkg::kind_t                  in_kind;
    logic [tcnf_pkg::IDX_W-1:0]       in_idx;
    logic                             in_auto;
    logic [63:0]                      in_val;
    logic [tcnf_pkg::CNT_W-1:0]       dc_ext;
    logic [tcnf_pkg::CNT_W-1:0]       dc_sat;

    // Item registers
    logic [63:0]                      val_reg,  val_next;
    tcnf_pkg::kind_t                  kind_reg, kind_next;
    logic                             auto_reg, auto_next;
    logic [tcnf_pkg::IDX_W-1:0]       idx_reg,  idx_next;
    logic [tcnf_pkg::BCD_W-1:0]       bcd_reg,  bcd_next;
    logic [tcnf_pkg::CONV_CNT_W-1:0]  conv_cnt_reg, conv_cnt_next;

    // Cursor and line width
    logic [7:0]                       cur_col_reg, cur_col_next;
    logic [7:0]                       cur_row_reg, cur_row_next;
    logic [7:0]                       lw_reg,      lw_next;

    // Output register
    logic [7:0]                       glyph_reg,  glyph_next;
    logic [7:0]                       column_reg, column_next;
    logic [7:0]                       row_reg,    row_next;
    logic                             last_reg,   last_next;
    logic                             out_valid_reg, out_valid_next;

    logic [tcnf_pkg::BCD_W-1:0]       bcd_adj;
    logic [tcnf_pkg::IDX_W-1:0]       lead_idx;
    logic [4*tcnf_pkg::MAX_CHARS-1:0] dec_pad;
    logic [7:0]                       glyph_sel;
    logic [7:0]                       threshold;
    logic [8:0]                       col_inc;
    logic                             wrap;
    logic [7:0]                       row_inc;

    always_comb
    begin
        dc_ext  = tcnf_pkg::CNT_W'(digit_count);
        if (dc_ext > tcnf_pkg::CNT_W'(tcnf_pkg::DEC_LIMIT))
            dc_sat = tcnf_pkg::CNT_W'(tcnf_pkg::DEC_LIMIT);
        else
            dc_sat = dc_ext;

        in_cls  = tcnf_pkg::CLS_NONE;
        in_kind = tcnf_pkg::KIND_CHAR;
        in_idx  = '0;
        in_auto = 1'b0;
        in_val  = value;
        unique case (opcode)
            tcnf_pkg::OP_CHAR:
            begin
                if (value[7:0] == tcnf_pkg::CHAR_NEWLINE)
                    in_cls = tcnf_pkg::CLS_NEWLINE;
                else
                    in_cls = tcnf_pkg::CLS_DIRECT;
            end
            tcnf_pkg::OP_HEX8:
            begin
                in_cls  = tcnf_pkg::CLS_DIRECT;
                in_kind = tcnf_pkg::KIND_HEX;
                in_idx  = tcnf_pkg::IDX_W'(1);
            end
            tcnf_pkg::OP_HEX16:
            begin
                in_cls  = tcnf_pkg::CLS_DIRECT;
                in_kind = tcnf_pkg::KIND_HEX;
                in_idx  = tcnf_pkg::IDX_W'(3);
            end
            tcnf_pkg::OP_HEX32:
            begin
                in_cls  = tcnf_pkg::CLS_DIRECT;
                in_kind = tcnf_pkg::KIND_HEX;
                in_idx  = tcnf_pkg::IDX_W'(7);
            end
            tcnf_pkg::OP_HEX64:
            begin
                in_cls  = tcnf_pkg::CLS_DIRECT;
                in_kind = tcnf_pkg::KIND_HEX;
                in_idx  = tcnf_pkg::IDX_W'(15);
            end
            tcnf_pkg::OP_BIN8:
            begin
                in_cls  = tcnf_pkg::CLS_DIRECT;
                in_kind = tcnf_pkg::KIND_BIN;
                in_idx  = tcnf_pkg::IDX_W'(7);
            end
            tcnf_pkg::OP_BIN16:
            begin
                in_cls  = tcnf_pkg::CLS_DIRECT;
                in_kind = tcnf_pkg::KIND_BIN;
                in_idx  = tcnf_pkg::IDX_W'(15);
            end
            tcnf_pkg::OP_DEC5:
            begin
                in_cls  = tcnf_pkg::CLS_DECIMAL;
                in_kind = tcnf_pkg::KIND_DEC;
                in_idx  = tcnf_pkg::IDX_W'(tcnf_pkg::DEC5_DIGITS - 1);
                in_val  = {48'b0, value[15:0]};
            end
            tcnf_pkg::OP_DECN:
            begin
                // zero digits prints nothing
                if (dc_sat != '0)
                    in_cls = tcnf_pkg::CLS_DECIMAL;
                in_kind = tcnf_pkg::KIND_DEC;
                in_idx  = tcnf_pkg::IDX_W'(dc_sat - 1'b1);
                in_val  = {48'b0, value[15:0]};
            end
            tcnf_pkg::OP_DECAUTO:
            begin
                in_cls  = tcnf_pkg::CLS_DECIMAL;
                in_kind = tcnf_pkg::KIND_DEC;
                in_auto = 1'b1;
                in_val  = {32'b0, value[31:0]};
            end
            tcnf_pkg::OP_NEWLINE:
            begin
                in_cls = tcnf_pkg::CLS_NEWLINE;
            end
            default:
            begin
                in_cls = tcnf_pkg::CLS_NONE;
            end
        endcase
    end

    // Double-dabble: add 3 to every digit of 5 or more before each shift
    always_comb
    begin
        for (int i = 0; i < tcnf_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Highest nonzero digit; zero still prints one digit
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < tcnf_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                lead_idx = tcnf_pkg::IDX_W'(i);
        end
    end

    always_comb
    begin
        dec_pad = {{tcnf_pkg::DEC_PAD_W{1'b0}}, bcd_reg};
        unique case (kind_reg)
            tcnf_pkg::KIND_CHAR: glyph_sel = val_reg[7:0];
            tcnf_pkg::KIND_HEX:  glyph_sel = tcnf_pkg::hex_glyph(val_reg[4*idx_reg +: 4]);
            tcnf_pkg::KIND_BIN:  glyph_sel = tcnf_pkg::ASCII_ZERO + {7'b0, val_reg[idx_reg]};
            tcnf_pkg::KIND_DEC:  glyph_sel = tcnf_pkg::ASCII_ZERO + {4'b0, dec_pad[4*idx_reg +: 4]};
            default:             glyph_sel = val_reg[7:0];
        endcase
    end

    always_comb
    begin
        threshold = (lw_reg <= 8'd1) ? 8'd0 : lw_reg - 8'd1;
        col_inc   = {1'b0, cur_col_reg} + 9'd1;
        wrap      = (col_inc >= {1'b0, threshold});
        row_inc   = (cur_row_reg == tcnf_pkg::ROW_MAX) ? cur_row_reg : cur_row_reg + 8'd1;
    end

    always_comb
    begin
        val_next      = val_reg;
        kind_next     = kind_reg;
        auto_next     = auto_reg;
        idx_next      = idx_reg;
        bcd_next      = bcd_reg;
        conv_cnt_next = conv_cnt_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        lw_next       = cfg_write ? cfg_data : lw_reg;
        glyph_next    = glyph_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        last_next     = last_reg;

        if (cmd.load)
        begin
            val_next      = in_val;
            kind_next     = in_kind;
            auto_next     = in_auto;
            idx_next      = in_idx;
            bcd_next      = '0;
            conv_cnt_next = '0;
        end

        if (cmd.conv_step)
        begin
            bcd_next      = {bcd_adj[tcnf_pkg::BCD_W-2:0], val_reg[tcnf_pkg::CONV_BITS-1]};
            val_next      = {val_reg[62:0], 1'b0};
            conv_cnt_next = conv_cnt_reg + 1'b1;
        end

        if (cmd.set_auto && auto_reg)
            idx_next = lead_idx;

        if (cmd.newline)
        begin
            cur_col_next = '0;
            cur_row_next = row_inc;
        end

        if (cmd.emit)
        begin
            glyph_next  = glyph_sel;
            column_next = cur_col_reg;
            row_next    = cur_row_reg;
            last_next   = (idx_reg == '0);
            idx_next    = idx_reg - 1'b1;
            if (wrap)
            begin
                cur_col_next = '0;
                cur_row_next = row_inc;
            end
            else
            begin
                cur_col_next = col_inc[7:0];
            end
        end

        // Hold the result until taken; a new character may replace it the same cycle
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            lw_reg        <= tcnf_pkg::LINE_WIDTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            lw_reg        <= lw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        kind_reg     <= kind_next;
        auto_reg     <= auto_next;
        idx_reg      <= idx_next;
        bcd_reg      <= bcd_next;
        conv_cnt_reg <= conv_cnt_next;
        glyph_reg    <= glyph_next;
        column_reg   <= column_next;
        row_reg      <= row_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        sts.cls       = in_cls;
        sts.conv_done = (conv_cnt_reg == tcnf_pkg::CONV_CNT_W'(tcnf_pkg::CONV_BITS - 1));
        sts.out_free  = !out_valid_reg || !out_stall;
        sts.idx_zero  = (idx_reg == '0);
    end

    assign glyph     = glyph_reg;
    assign column    = column_reg;
    assign row       = row_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted character not presented");

    a_newline_col: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.newline |=> (cur_col_reg == 8'd0))
        else $error("newline did not return the column to zero");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg != 8'hFF)
        else $error("cursor column out of range");

endmodule

`default_nettype wire

// ===== hdl/text_cursor_number_formatter.sv =====
// Channel  Handshake               Payload
// in       in_valid / in_stall     opcode, value, digit_count
// out      out_valid / out_stall   glyph, column, row, last
// cfg      cfg_write               cfg_data (line_width)
//
// One command at a time. Character, hex and binary commands emit their N
// characters directly; newline and ignored codes emit none.
// Decimal commands emit after conversion: a bit-serial BCD converter runs 32 steps.
// Reset clears the cursor to column 0, row 0 and sets line_width to 80.
// A stall on out holds the character register; the cursor advances only as
// characters enter it.
`default_nettype none

module text_cursor_number_formatter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  opcode,
    input  wire logic [63:0] value,
    input  wire logic [3:0]  digit_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       glyph,
    output logic [7:0]       column,
    output logic [7:0]       row,
    output logic             last
);

    tcnf_pkg::cmd_t cmd;
    tcnf_pkg::sts_t sts;

    tcnf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcnf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .value       (value),
        .digit_count (digit_count),
        .glyph       (glyph),
        .column      (column),
        .row         (row),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire
